// File: sv/rtrf_pkg.sv
package rtrf_pkg;

    localparam int TABLE_SLOTS_DEF = 8;
    localparam int MAX_PAYLOAD_DEF = 256;

    localparam int MAC_W   = 64;
    localparam int NET_W   = 16;
    localparam int ENTRY_W = MAC_W + NET_W;

    localparam logic [7:0]  FRAME_START  = 8'h7E;
    localparam int          HEADER_BYTES = 17;
    // length field counts everything after the length bytes except the checksum
    localparam logic [15:0] LEN_BASE     = 16'(HEADER_BYTES - 3);

    localparam int          CFG_ADDR_W        = 4;
    localparam logic [1:0]  REG_FRAME_TYPE    = 2'd0;
    localparam logic [1:0]  REG_RADIUS        = 2'd1;
    localparam logic [1:0]  REG_OPTIONS       = 2'd2;
    localparam logic [7:0]  FRAME_TYPE_RESET  = 8'd16;
    localparam logic [7:0]  RADIUS_RESET      = 8'd0;
    localparam logic [7:0]  OPTIONS_RESET     = 8'd0;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_REMOVE,
        KIND_START,
        KIND_PAYLOAD
    } kind_t;

    typedef enum logic [2:0] {
        RK_FRAME,
        RK_ADDED,
        RK_FULL,
        RK_FREED,
        RK_NOTFOUND
    } rk_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SEND,
        MODE_DROP
    } mode_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_ALWAYS,
        EM_IF_SEND
    } emit_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_IF_DATA,
        LAST_IF_MORE
    } last_t;

    typedef enum logic [3:0] {
        SEL_ZERO,
        SEL_SOF,
        SEL_LEN_HI,
        SEL_LEN_LO,
        SEL_TYPE,
        SEL_FID,
        SEL_MAC,
        SEL_NET_HI,
        SEL_NET_LO,
        SEL_RADIUS,
        SEL_OPTIONS,
        SEL_PAYLOAD,
        SEL_CHECKSUM
    } bsel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ADD,
        ACT_REMOVE,
        ACT_PAYLOAD,
        ACT_START,
        ACT_SCAN,
        ACT_MISS,
        ACT_MAC_SHIFT,
        ACT_HDR_DONE
    } act_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_END,
        JC_SCAN,
        JC_PLEN_ZERO,
        JC_PAY_FINAL
    } jc_t;

    localparam int PC_W = 5;

    localparam logic [PC_W-1:0] PC_ADD      = 5'd0;
    localparam logic [PC_W-1:0] PC_REMOVE   = 5'd1;
    localparam logic [PC_W-1:0] PC_PAYLOAD  = 5'd2;
    localparam logic [PC_W-1:0] PC_START    = 5'd3;
    localparam logic [PC_W-1:0] PC_SCAN     = 5'd4;
    localparam logic [PC_W-1:0] PC_MISS     = 5'd5;
    localparam logic [PC_W-1:0] PC_SOF      = 5'd6;
    localparam logic [PC_W-1:0] PC_LEN_HI   = 5'd7;
    localparam logic [PC_W-1:0] PC_LEN_LO   = 5'd8;
    localparam logic [PC_W-1:0] PC_TYPE     = 5'd9;
    localparam logic [PC_W-1:0] PC_FID      = 5'd10;
    localparam logic [PC_W-1:0] PC_MAC      = 5'd11;
    localparam logic [PC_W-1:0] PC_MAC_LAST = 5'd18;
    localparam logic [PC_W-1:0] PC_NET_HI   = 5'd19;
    localparam logic [PC_W-1:0] PC_NET_LO   = 5'd20;
    localparam logic [PC_W-1:0] PC_RADIUS   = 5'd21;
    localparam logic [PC_W-1:0] PC_OPTIONS  = 5'd22;
    localparam logic [PC_W-1:0] PC_CSUM     = 5'd23;

    typedef struct packed {
        emit_t               emit;
        bsel_t               bsel;
        rk_t                 rkind;
        logic                sum_en;
        last_t               last;
        act_t                act;
        jc_t                 jc;
        logic [PC_W-1:0]     target;
    } uword_t;

    typedef struct packed {
        logic   busy;
        uword_t word;
    } ctl_t;

    typedef struct packed {
        logic go;
        logic hit;
        logic scan_last;
        logic plen_zero;
        logic pay_final;
    } stat_t;

    typedef struct packed {
        logic [7:0] frame_type;
        logic [7:0] radius;
        logic [7:0] options;
    } cfg_t;

    function automatic uword_t mk(emit_t e, bsel_t b, rk_t r, logic s, last_t l,
                                  act_t a, jc_t j, logic [PC_W-1:0] t);
        uword_t w;
        w.emit   = e;
        w.bsel   = b;
        w.rkind  = r;
        w.sum_en = s;
        w.last   = l;
        w.act    = a;
        w.jc     = j;
        w.target = t;
        return w;
    endfunction

    // microprogram: one control word per step
    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        w = mk(EM_NONE, SEL_ZERO, RK_FRAME, 1'b0, LAST_NO, ACT_NONE, JC_END, PC_ADD);
        unique case (pc) inside
            PC_ADD:
                w = mk(EM_ALWAYS, SEL_ZERO, RK_ADDED, 1'b0, LAST_YES, ACT_ADD,
                       JC_END, PC_ADD);
            PC_REMOVE:
                w = mk(EM_ALWAYS, SEL_ZERO, RK_FREED, 1'b0, LAST_YES, ACT_REMOVE,
                       JC_END, PC_ADD);
            PC_PAYLOAD:
                w = mk(EM_IF_SEND, SEL_PAYLOAD, RK_FRAME, 1'b1, LAST_IF_MORE,
                       ACT_PAYLOAD, JC_PAY_FINAL, PC_CSUM);
            PC_START:
                w = mk(EM_NONE, SEL_ZERO, RK_FRAME, 1'b0, LAST_NO, ACT_START,
                       JC_NEXT, PC_ADD);
            PC_SCAN:
                w = mk(EM_NONE, SEL_ZERO, RK_FRAME, 1'b0, LAST_NO, ACT_SCAN,
                       JC_SCAN, PC_SOF);
            PC_MISS:
                w = mk(EM_ALWAYS, SEL_ZERO, RK_NOTFOUND, 1'b0, LAST_YES, ACT_MISS,
                       JC_END, PC_ADD);
            PC_SOF:
                w = mk(EM_ALWAYS, SEL_SOF, RK_FRAME, 1'b0, LAST_NO, ACT_NONE,
                       JC_NEXT, PC_ADD);
            PC_LEN_HI:
                w = mk(EM_ALWAYS, SEL_LEN_HI, RK_FRAME, 1'b0, LAST_NO, ACT_NONE,
                       JC_NEXT, PC_ADD);
            PC_LEN_LO:
                w = mk(EM_ALWAYS, SEL_LEN_LO, RK_FRAME, 1'b0, LAST_NO, ACT_NONE,
                       JC_NEXT, PC_ADD);
            PC_TYPE:
                w = mk(EM_ALWAYS, SEL_TYPE, RK_FRAME, 1'b1, LAST_NO, ACT_NONE,
                       JC_NEXT, PC_ADD);
            PC_FID:
                w = mk(EM_ALWAYS, SEL_FID, RK_FRAME, 1'b1, LAST_NO, ACT_NONE,
                       JC_NEXT, PC_ADD);
            [PC_MAC:PC_MAC_LAST]:
                w = mk(EM_ALWAYS, SEL_MAC, RK_FRAME, 1'b1, LAST_NO, ACT_MAC_SHIFT,
                       JC_NEXT, PC_ADD);
            PC_NET_HI:
                w = mk(EM_ALWAYS, SEL_NET_HI, RK_FRAME, 1'b1, LAST_NO, ACT_NONE,
                       JC_NEXT, PC_ADD);
            PC_NET_LO:
                w = mk(EM_ALWAYS, SEL_NET_LO, RK_FRAME, 1'b1, LAST_NO, ACT_NONE,
                       JC_NEXT, PC_ADD);
            PC_RADIUS:
                w = mk(EM_ALWAYS, SEL_RADIUS, RK_FRAME, 1'b1, LAST_NO, ACT_NONE,
                       JC_NEXT, PC_ADD);
            PC_OPTIONS:
                w = mk(EM_ALWAYS, SEL_OPTIONS, RK_FRAME, 1'b1, LAST_IF_DATA,
                       ACT_HDR_DONE, JC_PLEN_ZERO, PC_CSUM);
            PC_CSUM:
                w = mk(EM_ALWAYS, SEL_CHECKSUM, RK_FRAME, 1'b0, LAST_YES, ACT_NONE,
                       JC_END, PC_ADD);
            default:
                ;
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(kind_t k);
        logic [PC_W-1:0] pc;
        unique case (k)
            KIND_ADD:     pc = PC_ADD;
            KIND_REMOVE:  pc = PC_REMOVE;
            KIND_START:   pc = PC_START;
            KIND_PAYLOAD: pc = PC_PAYLOAD;
            default:      pc = PC_PAYLOAD;
        endcase
        return pc;
    endfunction

endpackage

// File: sv/rtrf_ram.sv
module rtrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rtrf_seq.sv
module rtrf_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  rtrf_pkg::kind_t kind,
    input  rtrf_pkg::stat_t stat,
    output rtrf_pkg::ctl_t  ctl
);

    logic                      busy_reg, busy_next;
    logic [rtrf_pkg::PC_W-1:0] pc_reg, pc_next;
    rtrf_pkg::uword_t          word;

    assign word = rtrf_pkg::ucode(pc_reg);

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = rtrf_pkg::entry_pc(kind);
        end
        else if (busy_reg && stat.go)
        begin
            unique case (word.jc)
                rtrf_pkg::JC_NEXT:
                    pc_next = pc_reg + 1'b1;
                rtrf_pkg::JC_END:
                    busy_next = 1'b0;
                rtrf_pkg::JC_SCAN:
                begin
                    // stay on the scan step until a hit or the last slot
                    if (stat.hit)
                    begin
                        pc_next = word.target;
                    end
                    else if (stat.scan_last)
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                rtrf_pkg::JC_PLEN_ZERO:
                begin
                    if (stat.plen_zero)
                    begin
                        pc_next = word.target;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                rtrf_pkg::JC_PAY_FINAL:
                begin
                    if (stat.pay_final)
                    begin
                        pc_next = word.target;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                    busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= rtrf_pkg::PC_ADD;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctl.busy = busy_reg;
    assign ctl.word = word;

endmodule

// File: sv/rtrf_dp.sv
module rtrf_dp #(
    parameter int TABLE_SLOTS = rtrf_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_PAYLOAD = rtrf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [63:0]     mac_address,
    input  logic [15:0]     network_address,
    input  logic [2:0]      table_slot,
    input  logic [8:0]      payload_length,
    input  logic [7:0]      payload_byte,
    input  rtrf_pkg::cfg_t  cfg,
    input  rtrf_pkg::ctl_t  ctl,
    output rtrf_pkg::stat_t stat,
    input  logic            out_stall,
    output logic            out_valid,
    output logic [2:0]      result_kind,
    output logic [7:0]      frame_byte,
    output logic            last_of_run,
    output logic [7:0]      frame_id,
    output logic [2:0]      added_slot
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    rtrf_pkg::uword_t word;
    assign word = ctl.word;

    // latched input item
    logic [63:0] mac_reg, mac_next;
    logic [15:0] net_in_reg;
    logic [2:0]  slot_in_reg;
    logic [8:0]  plen_reg;
    logic [7:0]  pbyte_reg;
    logic [8:0]  plen_clamped;

    // block state
    logic [TABLE_SLOTS-1:0] occ_reg, occ_next;
    logic [7:0]             fid_reg, fid_next;
    logic [7:0]             sum_reg, sum_next;
    logic [8:0]             rem_reg, rem_next;
    rtrf_pkg::mode_t        mode_reg, mode_next;
    logic [SLOT_W-1:0]      scan_reg, scan_next;
    logic [15:0]            hit_net_reg, hit_net_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    rtrf_pkg::rk_t   rk_reg, rk_sel;
    logic [7:0]      byte_reg, byte_sel;
    logic            last_reg, last_sel;
    logic [7:0]      fid_out_reg;
    logic [2:0]      slot_out_reg, slot_sel;

    logic [SLOT_W-1:0]                 free_slot;
    logic [SLOT_W-1:0]                 rm_idx;
    logic                              full;
    logic                              hit;
    logic                              scan_last;
    logic                              plen_zero;
    logic                              pay_final;
    logic                              mode_send;
    logic                              emit_req;
    logic                              can_emit;
    logic                              go;
    logic                              add_commit;
    logic [15:0]                       frame_len;
    logic [rtrf_pkg::ENTRY_W-1:0]      rdata;

    function automatic logic [31:0] table_slot_ext(logic [2:0] s);
        return {29'b0, s};
    endfunction

    assign plen_clamped = (32'(payload_length) > MAX_PAYLOAD) ? 9'(MAX_PAYLOAD)
                                                              : payload_length;

    always_comb
    begin
        free_slot = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign full      = &occ_reg;
    assign rm_idx    = SLOT_W'(table_slot_ext(slot_in_reg));
    assign hit       = occ_reg[scan_reg] &&
                       (rdata[rtrf_pkg::ENTRY_W-1:rtrf_pkg::NET_W] == mac_reg);
    assign scan_last = (scan_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign plen_zero = (plen_reg == 9'd0);
    assign mode_send = (mode_reg == rtrf_pkg::MODE_SEND);
    assign pay_final = mode_send && (rem_reg <= 9'd1);
    assign frame_len = rtrf_pkg::LEN_BASE + {7'b0, plen_reg};

    assign emit_req = ctl.busy &&
                      ((word.emit == rtrf_pkg::EM_ALWAYS) ||
                       ((word.emit == rtrf_pkg::EM_IF_SEND) && mode_send));
    assign can_emit = !out_valid_reg || !out_stall;
    assign go       = ctl.busy && (!emit_req || can_emit);
    assign add_commit = go && (word.act == rtrf_pkg::ACT_ADD) && !full;

    assign stat.go        = go;
    assign stat.hit       = hit;
    assign stat.scan_last = scan_last;
    assign stat.plen_zero = plen_zero;
    assign stat.pay_final = pay_final;

    rtrf_ram #(
        .WIDTH (rtrf_pkg::ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (add_commit),
        .waddr (free_slot),
        .wdata ({mac_reg, net_in_reg}),
        .raddr (scan_next),
        .rdata (rdata)
    );

    // byte and result selection for the current step
    always_comb
    begin
        case (word.bsel)
            rtrf_pkg::SEL_SOF:      byte_sel = rtrf_pkg::FRAME_START;
            rtrf_pkg::SEL_LEN_HI:   byte_sel = frame_len[15:8];
            rtrf_pkg::SEL_LEN_LO:   byte_sel = frame_len[7:0];
            rtrf_pkg::SEL_TYPE:     byte_sel = cfg.frame_type;
            rtrf_pkg::SEL_FID:      byte_sel = fid_reg;
            rtrf_pkg::SEL_MAC:      byte_sel = mac_reg[63:56];
            rtrf_pkg::SEL_NET_HI:   byte_sel = hit_net_reg[15:8];
            rtrf_pkg::SEL_NET_LO:   byte_sel = hit_net_reg[7:0];
            rtrf_pkg::SEL_RADIUS:   byte_sel = cfg.radius;
            rtrf_pkg::SEL_OPTIONS:  byte_sel = cfg.options;
            rtrf_pkg::SEL_PAYLOAD:  byte_sel = pbyte_reg;
            rtrf_pkg::SEL_CHECKSUM: byte_sel = ~sum_reg;
            default:                byte_sel = 8'h00;
        endcase

        rk_sel   = word.rkind;
        slot_sel = 3'b0;
        if (word.rkind == rtrf_pkg::RK_ADDED)
        begin
            if (full)
            begin
                rk_sel = rtrf_pkg::RK_FULL;
            end
            else
            begin
                slot_sel = 3'(free_slot);
            end
        end

        case (word.last)
            rtrf_pkg::LAST_YES:     last_sel = 1'b1;
            rtrf_pkg::LAST_IF_DATA: last_sel = !plen_zero;
            rtrf_pkg::LAST_IF_MORE: last_sel = !pay_final;
            default:                last_sel = 1'b0;
        endcase
    end

    // frame mode
    always_comb
    begin
        mode_next = mode_reg;
        if (go)
        begin
            unique case (word.act)
                rtrf_pkg::ACT_MISS:
                    mode_next = plen_zero ? rtrf_pkg::MODE_IDLE : rtrf_pkg::MODE_DROP;
                rtrf_pkg::ACT_HDR_DONE:
                    mode_next = plen_zero ? rtrf_pkg::MODE_IDLE : rtrf_pkg::MODE_SEND;
                rtrf_pkg::ACT_PAYLOAD:
                begin
                    if ((mode_reg != rtrf_pkg::MODE_IDLE) && (rem_reg <= 9'd1))
                    begin
                        mode_next = rtrf_pkg::MODE_IDLE;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    // datapath actions
    always_comb
    begin
        occ_next     = occ_reg;
        fid_next     = fid_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        scan_next    = scan_reg;
        hit_net_next = hit_net_reg;
        mac_next     = mac_reg;
        if (go)
        begin
            unique case (word.act)
                rtrf_pkg::ACT_ADD:
                begin
                    if (!full)
                    begin
                        occ_next[free_slot] = 1'b1;
                    end
                end
                rtrf_pkg::ACT_REMOVE:
                begin
                    // out-of-range slot reports freed and leaves the table alone
                    if (table_slot_ext(slot_in_reg) < TABLE_SLOTS)
                    begin
                        occ_next[rm_idx] = 1'b0;
                    end
                end
                rtrf_pkg::ACT_START:
                begin
                    fid_next  = fid_reg + 8'd1;
                    sum_next  = 8'h00;
                    scan_next = '0;
                end
                rtrf_pkg::ACT_SCAN:
                begin
                    hit_net_next = rdata[rtrf_pkg::NET_W-1:0];
                    if (!hit && !scan_last)
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                rtrf_pkg::ACT_MISS:
                    rem_next = plen_reg;
                rtrf_pkg::ACT_HDR_DONE:
                    rem_next = plen_reg;
                rtrf_pkg::ACT_MAC_SHIFT:
                    mac_next = {mac_reg[55:0], 8'h00};
                rtrf_pkg::ACT_PAYLOAD:
                begin
                    if ((mode_reg != rtrf_pkg::MODE_IDLE) && (rem_reg != 9'd0))
                    begin
                        rem_next = rem_reg - 9'd1;
                    end
                end
                default:
                    ;
            endcase
            if (emit_req && word.sum_en)
            begin
                sum_next = sum_reg + byte_sel;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go && emit_req)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            fid_reg       <= 8'h00;
            sum_reg       <= 8'h00;
            rem_reg       <= 9'd0;
            mode_reg      <= rtrf_pkg::MODE_IDLE;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            fid_reg       <= fid_next;
            sum_reg       <= sum_next;
            rem_reg       <= rem_next;
            mode_reg      <= mode_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_net_reg <= hit_net_next;
        if (accept)
        begin
            mac_reg     <= mac_address;
            net_in_reg  <= network_address;
            slot_in_reg <= table_slot;
            plen_reg    <= plen_clamped;
            pbyte_reg   <= payload_byte;
        end
        else
        begin
            mac_reg <= mac_next;
        end
        if (go && emit_req)
        begin
            rk_reg       <= rk_sel;
            byte_reg     <= byte_sel;
            last_reg     <= last_sel;
            fid_out_reg  <= fid_reg;
            slot_out_reg <= slot_sel;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = rk_reg;
    assign frame_byte  = byte_reg;
    assign last_of_run = last_reg;
    assign frame_id    = fid_out_reg;
    assign added_slot  = slot_out_reg;

    a_send_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == rtrf_pkg::MODE_SEND) |-> (rem_reg != 9'd0))
        else $error("sending frame with no payload bytes left");

    a_drop_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == rtrf_pkg::MODE_DROP) |-> (rem_reg != 9'd0))
        else $error("discarding with no payload bytes left");

    a_add_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        add_commit |=> occ_reg[$past(free_slot)])
        else $error("added slot not marked occupied");

endmodule

// File: sv/radio_tx_request_framer.sv
// Transmit-request framer with an 8-slot MAC to network address table, run by a
// small microprogram that steps one control word per cycle while no emitted
// byte waits on the output. Items are taken one at a time; in_stall is high
// while an item is being worked. A payload byte that closes a frame is followed
// by its checksum byte. A start item searches the table one slot a cycle
// through the single read port of the table RAM, up to the slot it hits or the
// last slot on a miss; a hit then emits the header bytes one per cycle (and the
// checksum straight after them for an empty payload), a miss one not-found
// result. Every emitted byte also waits for the output register to drain, so
// out_stall holds the sequence back. Table contents are not cleared at reset;
// only the occupied flags are.
module radio_tx_request_framer #(
    parameter int TABLE_SLOTS = rtrf_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_PAYLOAD = rtrf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtrf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [63:0]                     mac_address,
    input  logic [15:0]                     network_address,
    input  logic [2:0]                      table_slot,
    input  logic [8:0]                      payload_length,
    input  logic [7:0]                      payload_byte,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      result_kind,
    output logic [7:0]                      frame_byte,
    output logic                            last_of_run,
    output logic [7:0]                      frame_id,
    output logic [2:0]                      added_slot
);

    rtrf_pkg::cfg_t  cfg_reg, cfg_next;
    rtrf_pkg::ctl_t  ctl;
    rtrf_pkg::stat_t stat;
    logic            accept;
    logic            cfg_we;
    logic [1:0]      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                rtrf_pkg::REG_FRAME_TYPE: cfg_next.frame_type = pwdata[7:0];
                rtrf_pkg::REG_RADIUS:     cfg_next.radius     = pwdata[7:0];
                rtrf_pkg::REG_OPTIONS:    cfg_next.options    = pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            rtrf_pkg::REG_FRAME_TYPE: prdata = {24'b0, cfg_reg.frame_type};
            rtrf_pkg::REG_RADIUS:     prdata = {24'b0, cfg_reg.radius};
            rtrf_pkg::REG_OPTIONS:    prdata = {24'b0, cfg_reg.options};
            default:                  prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_type <= rtrf_pkg::FRAME_TYPE_RESET;
            cfg_reg.radius     <= rtrf_pkg::RADIUS_RESET;
            cfg_reg.options    <= rtrf_pkg::OPTIONS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = ctl.busy;
    assign accept   = in_valid && !ctl.busy;

    rtrf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (rtrf_pkg::kind_t'(kind)),
        .stat   (stat),
        .ctl    (ctl)
    );

    rtrf_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .mac_address     (mac_address),
        .network_address (network_address),
        .table_slot      (table_slot),
        .payload_length  (payload_length),
        .payload_byte    (payload_byte),
        .cfg             (cfg_reg),
        .ctl             (ctl),
        .stat            (stat),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .result_kind     (result_kind),
        .frame_byte      (frame_byte),
        .last_of_run     (last_of_run),
        .frame_id        (frame_id),
        .added_slot      (added_slot)
    );

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("item taken while sequencer not marked busy");

endmodule

// File: bench/framer_checker.sv
`timescale 1ns / 100ps
module framer_checker import rtrf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,

    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [63:0]           mac_address,
    input  logic [15:0]           network_address,
    input  logic [2:0]            table_slot,
    input  logic [8:0]            payload_length,
    input  logic [7:0]            payload_byte,

    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [2:0]            result_kind,
    input  logic [7:0]            frame_byte,
    input  logic                  last_of_run,
    input  logic [7:0]            frame_id,
    input  logic [2:0]            added_slot,

    output int                    fail_count,
    output int                    results_due,
    output int                    items_answered
);

    localparam int SLOTS      = TABLE_SLOTS_DEF;
    localparam int RUN_MAX    = HEADER_BYTES + 1;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        rk_t        rkind;
        logic [7:0] fbyte;
        logic       last;
        logic [7:0] fid;
        logic [2:0] slot;
    } reply_t;

    reply_t           due_q[$];
    reply_t           run_buf[RUN_MAX];
    int               run_len;
    reply_t           want;

    logic [63:0]      mac_tab[SLOTS];
    logic [15:0]      net_tab[SLOTS];
    logic [SLOTS-1:0] occupied;
    logic [7:0]       frame_seq;
    logic [7:0]       byte_sum;
    logic [8:0]       bytes_left;
    mode_t            mode;
    cfg_t             cfg;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    function automatic void emit_reply(rk_t rk, logic [7:0] b, logic [2:0] s);
        run_buf[run_len] = '{rkind: rk, fbyte: b, last: 1'b0, fid: frame_seq, slot: s};
        run_len++;
    endfunction

    function automatic void emit_frame_byte(logic [7:0] b, logic summed);
        if (summed)
            byte_sum += b;
        emit_reply(RK_FRAME, b, 3'd0);
    endfunction

    // works out every result one item causes and queues them in order
    task automatic predict_run(kind_t k, logic [63:0] mac, logic [15:0] net,
                               logic [2:0] slot, logic [8:0] plen_in, logic [7:0] pbyte);
        int          free_slot;
        int          hit;
        logic [8:0]  plen;
        logic [15:0] flen;
        reply_t      r;
        run_len = 0;
        case (k)
            KIND_ADD:
            begin
                free_slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!occupied[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot < 0)
                    emit_reply(RK_FULL, 8'd0, 3'd0);
                else
                begin
                    mac_tab[free_slot]  = mac;
                    net_tab[free_slot]  = net;
                    occupied[free_slot] = 1'b1;
                    emit_reply(RK_ADDED, 8'd0, 3'(free_slot));
                end
            end
            KIND_REMOVE:
            begin
                occupied[slot] = 1'b0;
                emit_reply(RK_FREED, 8'd0, 3'd0);
            end
            KIND_START:
            begin
                frame_seq++;
                plen = (plen_in > MAX_PAYLOAD_DEF) ? 9'(MAX_PAYLOAD_DEF) : plen_in;
                hit  = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (occupied[i] && mac_tab[i] == mac && hit < 0)
                        hit = i;
                bytes_left = plen;
                if (hit < 0)
                begin
                    emit_reply(RK_NOTFOUND, 8'd0, 3'd0);
                    mode = (plen != 0) ? MODE_DROP : MODE_IDLE;
                end
                else
                begin
                    flen     = LEN_BASE + 16'(plen);
                    byte_sum = '0;
                    emit_frame_byte(FRAME_START, 1'b0);
                    emit_frame_byte(flen[15:8], 1'b0);
                    emit_frame_byte(flen[7:0], 1'b0);
                    emit_frame_byte(cfg.frame_type, 1'b1);
                    emit_frame_byte(frame_seq, 1'b1);
                    for (int b = 7; b >= 0; b--)
                        emit_frame_byte(mac[8*b +: 8], 1'b1);
                    emit_frame_byte(net_tab[hit][15:8], 1'b1);
                    emit_frame_byte(net_tab[hit][7:0], 1'b1);
                    emit_frame_byte(cfg.radius, 1'b1);
                    emit_frame_byte(cfg.options, 1'b1);
                    if (plen == 0)
                    begin
                        emit_frame_byte(8'hFF - byte_sum, 1'b0);
                        mode = MODE_IDLE;
                    end
                    else
                        mode = MODE_SEND;
                end
            end
            default:
            begin
                if (mode == MODE_SEND)
                begin
                    emit_frame_byte(pbyte, 1'b1);
                    if (bytes_left > 0)
                        bytes_left--;
                    if (bytes_left == 0)
                    begin
                        emit_frame_byte(8'hFF - byte_sum, 1'b0);
                        mode = MODE_IDLE;
                    end
                end
                else if (mode == MODE_DROP)
                begin
                    // payload of an unknown destination is swallowed
                    if (bytes_left > 0)
                        bytes_left--;
                    if (bytes_left == 0)
                        mode = MODE_IDLE;
                end
            end
        endcase
        for (int i = 0; i < run_len; i++)
        begin
            r      = run_buf[i];
            r.last = (i == run_len - 1);
            due_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied       = '0;
            frame_seq      = '0;
            byte_sum       = '0;
            bytes_left     = '0;
            mode           = MODE_IDLE;
            cfg.frame_type = FRAME_TYPE_RESET;
            cfg.radius     = RADIUS_RESET;
            cfg.options    = OPTIONS_RESET;
            due_q.delete();
            results_due    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_q.size() == 0)
                    note_failure($sformatf(
                        "unexpected result: kind %0d byte %02h last %0b id %02h slot %0d",
                        result_kind, frame_byte, last_of_run, frame_id, added_slot));
                else
                begin
                    want = due_q.pop_front();
                    if (result_kind !== want.rkind || frame_byte !== want.fbyte ||
                        last_of_run !== want.last || frame_id !== want.fid ||
                        added_slot !== want.slot)
                        note_failure($sformatf({"result mismatch: expected kind %0d byte %02h",
                            " last %0b id %02h slot %0d, got kind %0d byte %02h last %0b",
                            " id %02h slot %0d"},
                            want.rkind, want.fbyte, want.last, want.fid, want.slot,
                            result_kind, frame_byte, last_of_run, frame_id, added_slot));
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_run(kind_t'(kind), mac_address, network_address, table_slot,
                            payload_length, payload_byte);
                if (run_len > 0)
                    items_answered++;
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                if (paddr[CFG_ADDR_W-1:2] == REG_FRAME_TYPE)
                    cfg.frame_type = pwdata[7:0];
                else if (paddr[CFG_ADDR_W-1:2] == REG_RADIUS)
                    cfg.radius = pwdata[7:0];
                else if (paddr[CFG_ADDR_W-1:2] == REG_OPTIONS)
                    cfg.options = pwdata[7:0];
            end
            results_due = due_q.size();
        end
    end

endmodule

// File: bench/radio_tx_request_framer_test.sv
`timescale 1ns / 100ps
module radio_tx_request_framer_test;
    import rtrf_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STUCK_LIMIT   = 3000;
    localparam int PHASE_ITEMS   = 38;

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr           = '0;
    logic [31:0]           pwdata          = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid        = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind            = '0;
    logic [63:0]           mac_address     = '0;
    logic [15:0]           network_address = '0;
    logic [2:0]            table_slot      = '0;
    logic [8:0]            payload_length  = '0;
    logic [7:0]            payload_byte    = '0;
    logic                  out_valid;
    logic                  out_stall       = 1'b0;
    logic [2:0]            result_kind;
    logic [7:0]            frame_byte;
    logic                  last_of_run;
    logic [7:0]            frame_id;
    logic [2:0]            added_slot;

    int                    send_idle_pct   = 0;
    int                    stall_pct       = 0;
    int                    stuck_cycles    = 0;
    int                    fail_count;
    int                    results_due;
    int                    items_answered;

    // what the stimulus believes the table holds, used to aim starts at real entries
    logic [63:0]                known_mac[TABLE_SLOTS_DEF];
    logic [TABLE_SLOTS_DEF-1:0] known_used = '0;

    radio_tx_request_framer u_dut (.*);

    framer_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .mac_address     (mac_address),
        .network_address (network_address),
        .table_slot      (table_slot),
        .payload_length  (payload_length),
        .payload_byte    (payload_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .frame_byte      (frame_byte),
        .last_of_run     (last_of_run),
        .frame_id        (frame_id),
        .added_slot      (added_slot),
        .fail_count      (fail_count),
        .results_due     (results_due),
        .items_answered  (items_answered)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL radio_tx_request_framer");
            $finish;
        end
    end

    function automatic logic [63:0] random_mac();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_used();
        int idx[$];
        for (int i = 0; i < TABLE_SLOTS_DEF; i++)
            if (known_used[i])
                idx.push_back(i);
        if (idx.size() == 0)
            return -1;
        return idx[$urandom_range(idx.size() - 1)];
    endfunction

    // called and left at a falling edge; valid stays up if another item follows
    task automatic put_item(kind_t k, logic [63:0] mac, logic [15:0] net, logic [2:0] slot,
                            logic [8:0] plen, logic [7:0] pbyte);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        kind            <= k;
        mac_address     <= mac;
        network_address <= net;
        table_slot      <= slot;
        payload_length  <= plen;
        payload_byte    <= pbyte;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic add_pair(logic [63:0] mac, logic [15:0] net);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < TABLE_SLOTS_DEF; i++)
            if (!known_used[i] && free_slot < 0)
                free_slot = i;
        if (free_slot >= 0)
        begin
            known_used[free_slot] = 1'b1;
            known_mac[free_slot]  = mac;
        end
        put_item(KIND_ADD, mac, net, 3'($urandom), 9'($urandom), 8'($urandom));
    endtask

    task automatic remove_slot(logic [2:0] s);
        known_used[s] = 1'b0;
        put_item(KIND_REMOVE, random_mac(), 16'($urandom), s, 9'($urandom), 8'($urandom));
    endtask

    task automatic start_frame(logic [63:0] mac, logic [8:0] plen);
        put_item(KIND_START, mac, 16'($urandom), 3'($urandom), plen, 8'($urandom));
    endtask

    task automatic send_byte(logic [7:0] b);
        put_item(KIND_PAYLOAD, random_mac(), 16'($urandom), 3'($urandom), 9'($urandom), b);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
    endtask

    task automatic apply_settings(logic [7:0] ftype, logic [7:0] radius, logic [7:0] opts);
        write_reg(REG_FRAME_TYPE, ftype);
        write_reg(REG_RADIUS, radius);
        write_reg(REG_OPTIONS, opts);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for every result, then give items that cause none time to finish
    task automatic drain();
        in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic directed_items();
        logic [63:0] mac_x;
        mac_x = 64'hA55A_C33C_0FF0_9669;
        send_byte(8'hFF);                       // payload with no frame open
        start_frame(64'h0123_4567_89AB_CDEF, 9'd0);  // empty table
        add_pair('1, 16'hFFFF);
        add_pair('0, 16'h0000);
        add_pair('1, 16'h1234);                 // duplicate MAC in slot 2
        start_frame('1, 9'd0);                  // header then checksum at once
        start_frame('0, 9'd2);
        send_byte(8'h00);
        add_pair(mac_x, 16'h5AA5);              // table change mid-frame
        send_byte(8'hFF);
        start_frame(mac_x, 9'd3);
        send_byte(8'hAA);
        start_frame('0, 9'd1);                  // abandons the frame above
        send_byte(8'h55);
        remove_slot(3'd0);
        start_frame('1, 9'd0);                  // freed slot must not match
        remove_slot(3'd7);                      // already free
        start_frame(64'hDEAD_BEEF_F00D_CAFE, 9'd2);
        send_byte(8'h3C);
        send_byte(8'hC3);
        repeat (6) add_pair(random_mac(), 16'($urandom));  // last one finds it full
    endtask

    task automatic long_frames();
        int s;
        s = pick_used();
        if (s < 0)
        begin
            add_pair(random_mac(), 16'($urandom));
            s = pick_used();
        end
        // oversized length is clipped to the largest payload
        start_frame(known_mac[s], 9'($urandom_range(511, 257)));
        repeat (MAX_PAYLOAD_DEF) send_byte(8'($urandom));
        start_frame(random_mac(), 9'd256);
        repeat (12) send_byte(8'($urandom));
    endtask

    task automatic random_traffic(int target);
        int          goal;
        int          r;
        int          s;
        int          plen;
        int          nbytes;
        logic [63:0] dest;
        goal = items_answered + target;
        while (items_answered < goal)
        begin
            r = $urandom_range(99);
            s = pick_used();
            if (r < 3)
                send_byte(8'($urandom));
            else if (r < 5)
            begin
                in_valid <= 1'b0;
                wait (results_due == 0);
                @(negedge clk);
            end
            else if (r < 22)
            begin
                if (s >= 0 && $urandom_range(6) == 0)
                    dest = known_mac[s];
                else
                    dest = random_mac();
                if (&known_used && $urandom_range(3) != 0)
                    remove_slot(3'(s));
                else
                    add_pair(dest, 16'($urandom));
            end
            else if (r < 35)
            begin
                if (s >= 0 && $urandom_range(4) != 0)
                    remove_slot(3'(s));
                else
                    remove_slot(3'($urandom));
            end
            else
            begin
                dest = (s >= 0 && $urandom_range(6) != 0) ? known_mac[s] : random_mac();
                r    = $urandom_range(99);
                if (r < 60)
                    plen = $urandom_range(4);
                else if (r < 95)
                    plen = $urandom_range(20, 5);
                else
                    plen = $urandom_range(40, 21);
                // now and then the frame is cut short by whatever comes next
                if (plen > 0 && $urandom_range(11) == 0)
                    nbytes = $urandom_range(plen - 1);
                else
                    nbytes = plen;
                start_frame(dest, 9'(plen));
                repeat (nbytes)
                begin
                    if ($urandom_range(24) == 0)
                    begin
                        if ($urandom_range(1) == 1)
                            add_pair(random_mac(), 16'($urandom));
                        else
                            remove_slot(3'($urandom));
                    end
                    send_byte(8'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apply_settings(8'hFF, 8'h00, 8'hFF);
        directed_items();
        long_frames();

        for (int p = 0; p < 4; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    apply_settings(8'h00, 8'hFF, 8'h00);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
                    send_idle_pct = 75;
                    stall_pct     = 0;
                end
                2:
                begin
                    apply_settings(FRAME_TYPE_RESET, 8'($urandom), 8'($urandom));
                    send_idle_pct = 0;
                    stall_pct     = 75;
                end
                default:
                begin
                    apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
            endcase
            random_traffic(PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("PASS radio_tx_request_framer");
        else
            $display("FAIL radio_tx_request_framer");
        $finish;
    end

endmodule

// File: files.f
sv/rtrf_pkg.sv
sv/rtrf_ram.sv
sv/rtrf_seq.sv
sv/rtrf_dp.sv
sv/radio_tx_request_framer.sv
bench/framer_checker.sv
bench/radio_tx_request_framer_test.sv
